@@ rtl/core/sse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSE parser package
// Shared result codes, line-mode encoding, prefix tables and the result
// struct passed from the parser core to the top level.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Result kinds
  localparam logic [2:0] KIND_DATA_START = 3'd0;
  localparam logic [2:0] KIND_DATA_BYTE  = 3'd1;
  localparam logic [2:0] KIND_NAME_START = 3'd2;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd3;
  localparam logic [2:0] KIND_EVENT_END  = 3'd4;

  // Special bytes and prefix lengths
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [2:0] DATA_PREFIX_LEN = 3'd6;
  localparam logic [2:0] NAME_PREFIX_LEN = 3'd7;

  // Line parsing mode, one-hot
  typedef enum logic [5:0] {
    MODE_LINE_START = 6'b000001,
    MODE_MATCH_DATA = 6'b000010,
    MODE_MATCH_NAME = 6'b000100,
    MODE_DATA_VALUE = 6'b001000,
    MODE_NAME_VALUE = 6'b010000,
    MODE_SKIP_LINE  = 6'b100000
  } line_mode_t;

  // One result of a parser step
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] value_byte;
    logic       deliver;
    logic       has_name;
  } sse_result_t;

  // "data: " by position
  function automatic logic [7:0] data_prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h64; // d
      3'd1:    c = 8'h61; // a
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h3A; // :
      3'd5:    c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "event: " by position
  function automatic logic [7:0] name_prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h65; // e
      3'd1:    c = 8'h76; // v
      3'd2:    c = 8'h65; // e
      3'd3:    c = 8'h6E; // n
      3'd4:    c = 8'h74; // t
      3'd5:    c = 8'h3A; // :
      3'd6:    c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/sse_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSE parser core
// Per-byte line and event state. Computes the result of the current byte
// combinationally and commits the new state when step is high.
// ----------------------------------------------------------------------------
module sse_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_i,
  output sse_pkg::sse_result_t res
);
  import sse_pkg::*;

  logic [1:0] line_end_run_r, line_end_run_nxt;
  logic       after_cr_r, after_cr_nxt;
  line_mode_t line_mode_r, line_mode_nxt;
  logic [2:0] prefix_pos_r, prefix_pos_nxt;
  logic       data_nonempty_r, data_nonempty_nxt;
  logic       name_present_r, name_present_nxt;
  logic [1:0] run_inc;
  logic [2:0] pos_inc;

  assign run_inc = line_end_run_r + 2'd1;
  assign pos_inc = prefix_pos_r + 3'd1;

  // Next state and result for one byte
  always_comb begin
    line_end_run_nxt  = line_end_run_r;
    after_cr_nxt      = 1'b0;
    line_mode_nxt     = line_mode_r;
    prefix_pos_nxt    = prefix_pos_r;
    data_nonempty_nxt = data_nonempty_r;
    name_present_nxt  = name_present_r;
    res               = '0;

    if (byte_i == CHAR_LF && after_cr_r) begin
      // second half of CRLF: drop
    end else if (byte_i == CHAR_CR || byte_i == CHAR_LF) begin
      after_cr_nxt     = (byte_i == CHAR_CR);
      line_mode_nxt    = MODE_LINE_START;
      prefix_pos_nxt   = 3'd0;
      line_end_run_nxt = run_inc;
      if (run_inc >= 2'd2) begin
        line_end_run_nxt  = 2'd0;
        data_nonempty_nxt = 1'b0;
        name_present_nxt  = 1'b0;
        res.valid    = 1'b1;
        res.kind     = KIND_EVENT_END;
        res.deliver  = data_nonempty_r;
        res.has_name = name_present_r;
      end
    end else begin
      line_end_run_nxt = 2'd0;
      unique case (line_mode_r)
        MODE_LINE_START: begin
          if (byte_i == data_prefix_char(3'd0)) begin
            line_mode_nxt  = MODE_MATCH_DATA;
            prefix_pos_nxt = 3'd1;
          end else if (byte_i == name_prefix_char(3'd0)) begin
            line_mode_nxt  = MODE_MATCH_NAME;
            prefix_pos_nxt = 3'd1;
          end else begin
            line_mode_nxt = MODE_SKIP_LINE;
          end
        end
        MODE_MATCH_DATA: begin
          if (prefix_pos_r < DATA_PREFIX_LEN && byte_i == data_prefix_char(prefix_pos_r)) begin
            prefix_pos_nxt = pos_inc;
            if (pos_inc == DATA_PREFIX_LEN) begin
              line_mode_nxt     = MODE_DATA_VALUE;
              data_nonempty_nxt = 1'b0;
              res.valid         = 1'b1;
              res.kind          = KIND_DATA_START;
            end
          end else begin
            line_mode_nxt = MODE_SKIP_LINE;
          end
        end
        MODE_MATCH_NAME: begin
          if (prefix_pos_r < NAME_PREFIX_LEN && byte_i == name_prefix_char(prefix_pos_r)) begin
            prefix_pos_nxt = pos_inc;
            if (pos_inc == NAME_PREFIX_LEN) begin
              line_mode_nxt    = MODE_NAME_VALUE;
              name_present_nxt = 1'b1;
              res.valid        = 1'b1;
              res.kind         = KIND_NAME_START;
            end
          end else begin
            line_mode_nxt = MODE_SKIP_LINE;
          end
        end
        MODE_DATA_VALUE: begin
          data_nonempty_nxt = 1'b1;
          res.valid         = 1'b1;
          res.kind          = KIND_DATA_BYTE;
          res.value_byte    = byte_i;
        end
        MODE_NAME_VALUE: begin
          res.valid      = 1'b1;
          res.kind       = KIND_NAME_BYTE;
          res.value_byte = byte_i;
        end
        default: begin
          // rest of an ignored line
        end
      endcase
    end
  end

  // Commit state on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_end_run_r  <= 2'd0;
      after_cr_r      <= 1'b0;
      line_mode_r     <= MODE_LINE_START;
      prefix_pos_r    <= 3'd0;
      data_nonempty_r <= 1'b0;
      name_present_r  <= 1'b0;
    end else if (step) begin
      line_end_run_r  <= line_end_run_nxt;
      after_cr_r      <= after_cr_nxt;
      line_mode_r     <= line_mode_nxt;
      prefix_pos_r    <= prefix_pos_nxt;
      data_nonempty_r <= data_nonempty_nxt;
      name_present_r  <= name_present_nxt;
    end
  end

endmodule

@@ rtl/core/sse_event_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSE event stream parser
// Parses a server-sent-events byte stream into value-start markers, tagged
// value bytes and event-end markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_byte) takes one stream byte per
//   item. Result channel (out_valid / out_stall / out_*) gives zero or one
//   result item per input byte, in stream order.
//   out_kind: data start, data byte, name start, name byte or event end.
//   out_value_byte is set for byte kinds; out_deliver and out_has_name are
//   set on event end.
//   Path: an accepted byte lands in the input register; the per-byte parse
//   logic then loads its result, if any, into the result register once the
//   result slot is free, and out_valid rises.
//   Throughput: one byte per cycle, unless a byte that makes a result waits
//   on a full, stalled result register.
//   Stall: while the result register is full and stalled, bytes that make no
//   result still drain; a byte that makes a result waits in the input
//   register and in_stall rises until the result slot frees.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to line start with no event open.
// ----------------------------------------------------------------------------
module sse_event_stream_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value_byte,
  output logic       out_deliver,
  output logic       out_has_name
);
  import sse_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  byte_r;
  logic        out_valid_r, out_valid_nxt;
  sse_result_t res;
  sse_result_t res_r;
  logic        out_free;
  logic        proc_go;

  // Parse the held byte
  sse_parser_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (proc_go),
    .byte_i (byte_r),
    .res    (res)
  );

  // Advance the held byte when its result, if any, has a slot
  assign out_free = !out_valid_r || !out_stall;
  assign proc_go  = in_valid_r && (!res.valid || out_free);
  assign in_stall = in_valid_r && !proc_go;

  // Input register
  assign in_valid_nxt = in_stall ? in_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  // Result register
  always_comb begin
    if (proc_go && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res.valid) begin
      res_r <= res;
    end
  end

  // Drive the result ports
  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_value_byte = res_r.value_byte;
  assign out_deliver    = res_r.deliver;
  assign out_has_name   = res_r.has_name;

endmodule

@@ dv/sse_event_stream_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSE event stream parser testbench
// Feeds byte streams into the parser: a short hand-built stream first, then
// random events made of data, name, partial-prefix and junk lines with mixed
// CR / LF / CRLF line ends. A parse model in the bench predicts every result
// item, and the monitor checks each one field by field, in order. Both
// channels idle at random in three mixes, and the output side is held off
// once for a long stretch.
// ----------------------------------------------------------------------------
module sse_event_stream_parser_tb;
  import sse_pkg::*;

  localparam int CLK_HALF       = 1;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int PHASE_BYTES    = 200;
  localparam int END_WAIT       = 10;

  // Field tags, right aligned: character i of a tag of len characters sits at byte len-1-i
  localparam logic [55:0] DATA_FIELD_TAG = {8'h00, "data: "};
  localparam logic [55:0] NAME_FIELD_TAG = "event: ";

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value_byte;
    logic       deliver;
    logic       has_name;
  } parse_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_value_byte;
  logic       out_deliver;
  logic       out_has_name;

  // Stimulus and scoreboard storage
  logic [7:0]    pending_bytes[$];
  parse_result_t expected_results[$];

  // Parse model state
  logic [1:0] line_end_count;
  logic       last_was_cr;
  line_mode_t parse_mode;
  logic [2:0] tag_pos;
  logic       data_has_bytes;
  logic       name_seen;

  // Traffic control and counters
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_hold_ask = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int events_seen = 0;
  logic in_fire = 1'b0;

  sse_event_stream_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value_byte (out_value_byte),
    .out_deliver    (out_deliver),
    .out_has_name   (out_has_name)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Return the parser model to line start with no event open
  task automatic clear_parse_state();
    line_end_count = 2'd0;
    last_was_cr    = 1'b0;
    parse_mode     = MODE_LINE_START;
    tag_pos        = 3'd0;
    data_has_bytes = 1'b0;
    name_seen      = 1'b0;
  endtask

  // Advance the parse model by one byte; return 1 when it yields a result
  function automatic bit parse_byte(input logic [7:0] b, output parse_result_t r);
    logic was_cr;
    was_cr = last_was_cr;
    r = '0;
    last_was_cr = 1'b0;
    // LF right after CR belongs to the same line end
    if (b == CHAR_LF && was_cr) return 1'b0;
    if (b == CHAR_CR || b == CHAR_LF) begin
      last_was_cr    = (b == CHAR_CR);
      parse_mode     = MODE_LINE_START;
      tag_pos        = 3'd0;
      line_end_count = line_end_count + 2'd1;
      if (line_end_count >= 2'd2) begin
        r.kind         = KIND_EVENT_END;
        r.deliver      = data_has_bytes;
        r.has_name     = name_seen;
        line_end_count = 2'd0;
        data_has_bytes = 1'b0;
        name_seen      = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    line_end_count = 2'd0;
    case (parse_mode)
      MODE_LINE_START: begin
        tag_pos = 3'd1;
        if (b == DATA_FIELD_TAG[8*(DATA_PREFIX_LEN-1) +: 8]) parse_mode = MODE_MATCH_DATA;
        else if (b == NAME_FIELD_TAG[8*(NAME_PREFIX_LEN-1) +: 8]) parse_mode = MODE_MATCH_NAME;
        else parse_mode = MODE_SKIP_LINE;
        return 1'b0;
      end
      MODE_MATCH_DATA: begin
        if (b != DATA_FIELD_TAG[8*(DATA_PREFIX_LEN-1-tag_pos) +: 8]) begin
          parse_mode = MODE_SKIP_LINE;
          return 1'b0;
        end
        tag_pos = tag_pos + 3'd1;
        if (tag_pos != DATA_PREFIX_LEN) return 1'b0;
        parse_mode     = MODE_DATA_VALUE;
        data_has_bytes = 1'b0;
        r.kind         = KIND_DATA_START;
        return 1'b1;
      end
      MODE_MATCH_NAME: begin
        if (b != NAME_FIELD_TAG[8*(NAME_PREFIX_LEN-1-tag_pos) +: 8]) begin
          parse_mode = MODE_SKIP_LINE;
          return 1'b0;
        end
        tag_pos = tag_pos + 3'd1;
        if (tag_pos != NAME_PREFIX_LEN) return 1'b0;
        parse_mode = MODE_NAME_VALUE;
        name_seen  = 1'b1;
        r.kind     = KIND_NAME_START;
        return 1'b1;
      end
      MODE_DATA_VALUE: begin
        data_has_bytes = 1'b1;
        r.kind         = KIND_DATA_BYTE;
        r.value_byte   = b;
        return 1'b1;
      end
      MODE_NAME_VALUE: begin
        r.kind       = KIND_NAME_BYTE;
        r.value_byte = b;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // CR, LF or CRLF at random
  task automatic push_line_end();
    case ($urandom_range(0, 2))
      0: push_byte(CHAR_CR);
      1: push_byte(CHAR_LF);
      default: begin
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end
    endcase
  endtask

  // First keep characters of a field tag of len characters
  task automatic push_prefix(input logic [55:0] tag, input int len, input int keep);
    for (int i = 0; i < keep; i++) push_byte(tag[8*(len-1-i) +: 8]);
  endtask

  // Random value bytes that do not end the line
  task automatic push_value(input int n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom_range(0, 255));
      if (v == CHAR_CR || v == CHAR_LF) v = 8'h80;
      push_byte(v);
    end
  endtask

  // One event: a few lines of mixed kinds, then the closing line end
  task automatic push_event();
    int sel;
    int nlines;
    nlines = $urandom_range(1, 3);
    for (int l = 0; l < nlines; l++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        push_prefix(DATA_FIELD_TAG, DATA_PREFIX_LEN, DATA_PREFIX_LEN);
        push_value($urandom_range(0, 6));
      end else if (sel < 60) begin
        push_prefix(NAME_FIELD_TAG, NAME_PREFIX_LEN, NAME_PREFIX_LEN);
        push_value($urandom_range(0, 5));
      end else if (sel < 72) begin
        // broken prefix, sometimes followed by a wrong character and junk
        if ($urandom_range(0, 1))
          push_prefix(DATA_FIELD_TAG, DATA_PREFIX_LEN, $urandom_range(1, DATA_PREFIX_LEN - 1));
        else
          push_prefix(NAME_FIELD_TAG, NAME_PREFIX_LEN, $urandom_range(1, NAME_PREFIX_LEN - 1));
        if ($urandom_range(0, 1)) begin
          push_byte(8'h58);
          push_value($urandom_range(0, 3));
        end
      end else if (sel < 85) begin
        push_value($urandom_range(1, 5));
      end else begin
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          case ($urandom_range(0, 6))
            0: push_byte(CHAR_CR);
            1: push_byte(CHAR_LF);
            2: push_byte("d");
            3: push_byte("e");
            4: push_byte(":");
            5: push_byte(" ");
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
      push_line_end();
    end
    push_line_end();
    // now and then an empty event right after
    if ($urandom_range(0, 19) == 0) begin
      push_line_end();
      push_line_end();
    end
  endtask

  task automatic push_stream(input int n);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < n) push_event();
  endtask

  // Wait until every byte is taken and every result has come
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_field(input string fname, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, seen);
      mismatches++;
    end
  endtask

  // Sender: offer the next item at the falling edge, hold it while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold when one is asked for
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_hold_ask != rx_hold_seen) begin
        rx_hold_seen = rx_hold_ask;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Monitor: check taken results, predict from taken bytes
  always @(posedge clk) begin
    parse_result_t want;
    parse_result_t got;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_kind == KIND_EVENT_END) events_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                   $time, out_kind, out_value_byte);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("kind", want.kind, out_kind);
          report_field("value_byte", want.value_byte, out_value_byte);
          report_field("deliver", want.deliver, out_deliver);
          report_field("has_name", want.has_name, out_has_name);
        end
      end
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (parse_byte(in_byte, got)) expected_results.push_back(got);
      end
      in_fire <= in_valid && !in_stall;
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run when traffic stops for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no traffic for %0d cycles, %0d results still expected",
             $time, QUIET_LIMIT, expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    clear_parse_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily
    send_idle_pct = 27;
    recv_idle_pct = 63;
    // data line with extreme value bytes, closed by CRLF
    push_prefix(DATA_FIELD_TAG, DATA_PREFIX_LEN, DATA_PREFIX_LEN);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    // name line with an empty value
    push_prefix(NAME_FIELD_TAG, NAME_PREFIX_LEN, NAME_PREFIX_LEN);
    push_byte(CHAR_LF);
    // line cut short inside its prefix, then the event end
    push_byte("d");
    push_byte("a");
    push_byte(CHAR_LF);
    push_byte(CHAR_LF);
    // event with no field lines at all
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    push_stream(PHASE_BYTES);
    wait_drained();

    // Phase two: roles swapped
    send_idle_pct = 63;
    recv_idle_pct = 27;
    push_stream(PHASE_BYTES);
    wait_drained();

    // Phase three: no idling, one long output hold to back the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_stream(PHASE_BYTES);
    rx_hold_ask++;
    // leave the last event open
    push_prefix(DATA_FIELD_TAG, DATA_PREFIX_LEN, DATA_PREFIX_LEN);
    push_value(3);
    wait_drained();
    repeat (END_WAIT) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Parsed %0d stream bytes into %0d result items, %0d of them event ends,",
             bytes_taken, results_seen, events_seen);
    $display("across three stall mixes and one long output hold; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sse_event_stream_parser.f @@
rtl/core/sse_pkg.sv
rtl/core/sse_parser_core.sv
rtl/core/sse_event_stream_parser.sv
dv/sse_event_stream_parser_tb.sv
